// ----- design/masort_pkg.sv -----
// Shared constants, state encoding and control structs of the anti-diagonal sorter.
`timescale 1ns / 1ps

package masort_pkg;

   localparam int MAX_N_DEF = 8;
   localparam int CSR_W     = 4;
   localparam int DATA_W    = 32;
   localparam logic [CSR_W-1:0] SIZE_RESET = 4'd8;

   typedef enum logic [8:0] {
      S_LOAD  = 9'b000000001,
      S_DINIT = 9'b000000010,
      S_DRD   = 9'b000000100,
      S_DCAP  = 9'b000001000,
      S_DSORT = 9'b000010000,
      S_DWR   = 9'b000100000,
      S_DNEXT = 9'b001000000,
      S_ERD   = 9'b010000000,
      S_ELD   = 9'b100000000
   } state_type;

   typedef struct packed {
      logic load;
      logic sort_start;
      logic diag_init;
      logic rd;
      logic sort_prep;
      logic sort_step;
      logic wr;
      logic next_diag;
      logic emit_start;
      logic emit_rd;
      logic emit_ld;
   } cmd_type;

   typedef struct packed {
      logic load_full;
      logic rd_last;
      logic sort_last;
      logic wr_last;
      logic last_diag;
      logic out_free;
      logic emit_last;
   } sts_type;

endpackage

// ----- design/masort_req_if.sv -----
// Input channel: one matrix element per word.
`timescale 1ns / 1ps

interface masort_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [masort_pkg::DATA_W-1:0] element_value;

   modport source (output valid, output element_value, input ready);
   modport sink   (input valid, input element_value, output ready);
endinterface

// ----- design/masort_rsp_if.sv -----
// Result channel: sorted matrix element per word, with end-of-matrix flag.
`timescale 1ns / 1ps

interface masort_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [masort_pkg::DATA_W-1:0] result_value;
   logic                                last_of_matrix;

   modport source (output valid, output result_value, output last_of_matrix, input ready);
   modport sink   (input valid, input result_value, input last_of_matrix, output ready);
endinterface

// ----- design/matrix_antidiagonal_sorter_top.sv -----
// Loading: one word per cycle while a word is offered; after the last word, each
// anti-diagonal is read, sorted by MAX_N odd-even passes and written back through one store port,
// then each word is emitted by a store read and an output-register load that waits for a free output.
// A new matrix is accepted only after the last word of the previous one has been emitted.
// Reset: synchronous; size returns to 8, load count to zero; store contents are not cleared.
`timescale 1ns / 1ps

module matrix_antidiagonal_sorter_top #(
   parameter int MAX_N = masort_pkg::MAX_N_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   masort_req_if.sink                   req_if,
   masort_rsp_if.source                 rsp_if,
   input  logic                         csr_write_enable,
   input  logic [masort_pkg::CSR_W-1:0] csr_write_data
);

   masort_pkg::cmd_type cmd;
   masort_pkg::sts_type sts;

   masort_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   masort_datapath #(
      .MAX_N (MAX_N)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_value        (req_if.element_value),
      .rsp_ready        (rsp_if.ready),
      .rsp_valid        (rsp_if.valid),
      .rsp_value        (rsp_if.result_value),
      .rsp_last         (rsp_if.last_of_matrix)
   );

endmodule

// ----- design/masort_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module masort_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/masort_datapath.sv -----
// Datapath: size register, load counter, matrix store, diagonal buffer and sorter, output register.
`timescale 1ns / 1ps

module masort_datapath #(
   parameter int MAX_N = masort_pkg::MAX_N_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  masort_pkg::cmd_type                  cmd,
   output masort_pkg::sts_type                  sts,
   input  logic                                 csr_write_enable,
   input  logic [masort_pkg::CSR_W-1:0]         csr_write_data,
   input  logic signed [masort_pkg::DATA_W-1:0] req_value,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic signed [masort_pkg::DATA_W-1:0] rsp_value,
   output logic                                 rsp_last
);

   localparam int DEPTH  = MAX_N * MAX_N;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int NW     = $clog2(MAX_N + 1);
   localparam int IW     = (MAX_N > 1) ? $clog2(MAX_N) : 1;
   localparam int DW     = $clog2(2 * MAX_N);
   localparam int W      = masort_pkg::DATA_W;
   localparam logic [W-1:0] FILL = {1'b0, {(W-1){1'b1}}};

   logic [masort_pkg::CSR_W-1:0] size_ff;
   logic [NW-1:0]                n;
   logic [2*NW-1:0]              sq;
   logic [CNT_W-1:0]             total;

   logic [CNT_W-1:0]  load_count_ff;
   logic [CNT_W:0]    load_next;
   logic [DW-1:0]     diag_ff;
   logic [DW:0]       diag_p1;
   logic [DW:0]       diag_p2;
   logic [DW:0]       n_ext;
   logic [ADDR_W-1:0] dstart_ff;
   logic [NW-1:0]     dcnt_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] addr_step;
   logic [NW-1:0]     idx_ff;
   logic [NW-1:0]     pass_ff;
   logic              cap_ff;
   logic [IW-1:0]     slot_ff;
   logic [W-1:0]      buf_ff [MAX_N];
   logic [W-1:0]      sorted [MAX_N];
   logic [CNT_W-1:0]  kout_ff;
   logic              rsp_valid_ff;
   logic [W-1:0]      rsp_value_ff;
   logic              rsp_last_ff;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [W-1:0]      ram_wdata;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [W-1:0]      ram_rdata;

   // effective size: zero reads as one, large values saturate
   always_comb begin
      if (size_ff == '0) begin
         n = NW'(1);
      end else if (int'(size_ff) > MAX_N) begin
         n = NW'(MAX_N);
      end else begin
         n = NW'(size_ff);
      end
   end

   assign sq        = n * n;
   assign total     = CNT_W'(sq);
   assign load_next = {1'b0, load_count_ff} + (CNT_W+1)'(1);
   assign diag_p1   = {1'b0, diag_ff} + (DW+1)'(1);
   assign diag_p2   = {1'b0, diag_ff} + (DW+1)'(2);
   assign n_ext     = (DW+1)'(n);
   assign addr_step = ADDR_W'(addr_ff + ADDR_W'(n) - ADDR_W'(1));

   always_comb begin
      sts.load_full = load_next >= {1'b0, total};
      sts.rd_last   = idx_ff == NW'(dcnt_ff - NW'(1));
      sts.sort_last = pass_ff == NW'(MAX_N - 1);
      sts.wr_last   = idx_ff == NW'(dcnt_ff - NW'(1));
      sts.last_diag = diag_p2 == (DW+1)'({n_ext, 1'b0});
      sts.out_free  = !rsp_valid_ff || rsp_ready;
      sts.emit_last = kout_ff == CNT_W'(total - CNT_W'(1));
   end

   // odd-even transposition pass
   always_comb begin
      for (int i = 0; i < MAX_N; i++) begin
         sorted[i] = buf_ff[i];
      end
      for (int i = 0; i < MAX_N - 1; i++) begin
         if (((i % 2) == int'(pass_ff[0])) &&
             ($signed(buf_ff[i+1]) < $signed(buf_ff[i]))) begin
            sorted[i]   = buf_ff[i+1];
            sorted[i+1] = buf_ff[i];
         end
      end
   end

   always_comb begin
      ram_we    = cmd.load || cmd.wr;
      ram_waddr = cmd.load ? load_count_ff[ADDR_W-1:0] : addr_ff;
      ram_wdata = cmd.load ? req_value : buf_ff[0];
      ram_re    = cmd.rd || cmd.emit_rd;
      ram_raddr = cmd.rd ? addr_ff : kout_ff[ADDR_W-1:0];
   end

   masort_ram #(
      .WIDTH (W),
      .DEPTH (DEPTH),
      .AW    (ADDR_W)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff       <= masort_pkg::SIZE_RESET;
         load_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         cap_ff        <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            size_ff <= csr_write_data;
         end
         if (cmd.load) begin
            load_count_ff <= cmd.sort_start ? '0 : load_next[CNT_W-1:0];
         end
         if (cmd.emit_ld) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         cap_ff <= cmd.rd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sort_start) begin
         diag_ff   <= '0;
         dstart_ff <= '0;
         dcnt_ff   <= NW'(1);
      end else if (cmd.next_diag) begin
         diag_ff <= diag_p1[DW-1:0];
         if (diag_p1 < n_ext) begin
            dstart_ff <= ADDR_W'(dstart_ff + ADDR_W'(1));
            dcnt_ff   <= NW'(dcnt_ff + NW'(1));
         end else begin
            dstart_ff <= ADDR_W'(dstart_ff + ADDR_W'(n));
            dcnt_ff   <= NW'(dcnt_ff - NW'(1));
         end
      end

      if (cmd.diag_init || cmd.sort_prep) begin
         addr_ff <= dstart_ff;
         idx_ff  <= '0;
      end else if (cmd.rd || cmd.wr) begin
         addr_ff <= addr_step;
         idx_ff  <= NW'(idx_ff + NW'(1));
      end

      if (cmd.diag_init) begin
         pass_ff <= '0;
      end else if (cmd.sort_step) begin
         pass_ff <= NW'(pass_ff + NW'(1));
      end

      slot_ff <= idx_ff[IW-1:0];

      if (cmd.diag_init) begin
         for (int i = 0; i < MAX_N; i++) begin
            buf_ff[i] <= FILL;
         end
      end else if (cmd.sort_step) begin
         for (int i = 0; i < MAX_N; i++) begin
            buf_ff[i] <= sorted[i];
         end
      end else if (cmd.wr) begin
         for (int i = 0; i < MAX_N - 1; i++) begin
            buf_ff[i] <= buf_ff[i+1];
         end
         buf_ff[MAX_N-1] <= FILL;
      end
      if (cap_ff) begin
         buf_ff[slot_ff] <= ram_rdata;
      end

      if (cmd.emit_start) begin
         kout_ff <= '0;
      end else if (cmd.emit_ld) begin
         kout_ff <= CNT_W'(kout_ff + CNT_W'(1));
      end

      if (cmd.emit_ld) begin
         rsp_value_ff <= ram_rdata;
         rsp_last_ff  <= sts.emit_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

// ----- design/masort_controller.sv -----
// Controller: sequences load, per-diagonal read, sort and write-back, then emission.
`timescale 1ns / 1ps

module masort_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  masort_pkg::sts_type sts,
   output masort_pkg::cmd_type cmd
);

   masort_pkg::state_type state_ff;
   masort_pkg::state_type state_in;
   logic                  accept;

   assign req_ready = state_ff == masort_pkg::S_LOAD;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         masort_pkg::S_LOAD: begin
            cmd.load       = accept;
            cmd.sort_start = accept && sts.load_full;
            if (accept && sts.load_full) begin
               state_in = masort_pkg::S_DINIT;
            end
         end
         masort_pkg::S_DINIT: begin
            cmd.diag_init = 1'b1;
            state_in      = masort_pkg::S_DRD;
         end
         masort_pkg::S_DRD: begin
            cmd.rd = 1'b1;
            if (sts.rd_last) begin
               state_in = masort_pkg::S_DCAP;
            end
         end
         masort_pkg::S_DCAP: begin
            cmd.sort_prep = 1'b1;
            state_in      = masort_pkg::S_DSORT;
         end
         masort_pkg::S_DSORT: begin
            cmd.sort_step = 1'b1;
            if (sts.sort_last) begin
               state_in = masort_pkg::S_DWR;
            end
         end
         masort_pkg::S_DWR: begin
            cmd.wr = 1'b1;
            if (sts.wr_last) begin
               state_in = masort_pkg::S_DNEXT;
            end
         end
         masort_pkg::S_DNEXT: begin
            if (sts.last_diag) begin
               cmd.emit_start = 1'b1;
               state_in       = masort_pkg::S_ERD;
            end else begin
               cmd.next_diag = 1'b1;
               state_in      = masort_pkg::S_DINIT;
            end
         end
         masort_pkg::S_ERD: begin
            cmd.emit_rd = 1'b1;
            state_in    = masort_pkg::S_ELD;
         end
         masort_pkg::S_ELD: begin
            if (sts.out_free) begin
               cmd.emit_ld = 1'b1;
               state_in    = sts.emit_last ? masort_pkg::S_LOAD : masort_pkg::S_ERD;
            end
         end
         default: begin
            state_in = masort_pkg::S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= masort_pkg::S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
